/* design/scp_pkg.sv */
// ----------------------------------------------------------------------------
// Skyline chart placer package
// Shared constants and types for the chart placer.
// ----------------------------------------------------------------------------
package scp_pkg;

   localparam int SkylineCells = 1024;
   localparam int ProfileCells = 256;
   localparam int SkyAw        = $clog2(SkylineCells);
   localparam int ProAw        = $clog2(ProfileCells);
   localparam logic [23:0] WasteMax = 24'hFFFFFF;

   typedef enum logic [1:0] {
      KIND_CLEAR = 2'd0,
      KIND_LOAD  = 2'd1,
      KIND_PLACE = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_LIFT_RD,
      ST_LIFT,
      ST_WASTE_RD,
      ST_WASTE,
      ST_NEXT,
      ST_WR_RD,
      ST_WR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] lower_edge;
      logic [15:0] upper_edge;
      logic        last_column;
      logic [14:0] chart_height;
   } req_type;

   typedef struct packed {
      logic        placed;
      logic [9:0]  pos_x;
      logic [9:0]  pos_y;
      logic [23:0] waste_area;
   } rsp_type;

endpackage

/* design/scp_if.sv */
// ----------------------------------------------------------------------------
// Chart placer channel interfaces
// Valid/ready channels for request and response items.
// ----------------------------------------------------------------------------
interface scp_req_if import scp_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface scp_rsp_if import scp_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* design/skyline_chart_placer.sv */
// ----------------------------------------------------------------------------
// Skyline chart placer
// Places charts on a skyline by least waste area.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  req     | in  | req.valid/ready    | kind, lower/upper edge, last, height
//  rsp     | out | rsp.valid/ready    | placed, pos_x, pos_y, waste_area
//  csr     | in  | csr_wr_en          | bin_cells
// Load and kind 3 items leave the placer idle; clear sweeps all SkylineCells cells.
// Place scans the positions that fit usable width W for profile length L,
// one skyline read per cycle: a lift pass, a waste pass, then a write back.
// Reset is synchronous; the skyline is cleared by a sweep after reset
// of all SkylineCells cells during which no item is taken.
// A result waits in an output register while further items are taken; a
// place holds its last cycle until that register is free.
// ----------------------------------------------------------------------------
module skyline_chart_placer import scp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   scp_req_if.sink     req,
   scp_rsp_if.source   rsp,
   input  logic        csr_wr_en,
   input  logic [10:0] csr_wr_data
);

   logic signed [15:0] sky_mem [SkylineCells];
   logic signed [15:0] lo_mem [ProfileCells];
   logic signed [15:0] up_mem [ProfileCells];

   state_type state_ff, state_in;
   logic [10:0]       bin_ff;
   logic [ProAw:0]    len_ff, len_in;
   logic              closed_ff, closed_in;
   logic [SkyAw:0]    x_ff, x_in;
   logic [ProAw:0]    i_ff, i_in;
   logic [SkyAw:0]    clr_ff, clr_in;
   logic signed [16:0] lift_ff, lift_in;
   logic [23:0]       waste_ff, waste_in;
   logic [14:0]       height_ff, height_in;
   logic              found_ff, found_in;
   logic [SkyAw:0]    px_ff, px_in;
   logic signed [16:0] plift_ff, plift_in;
   logic [23:0]       pwaste_ff, pwaste_in;
   logic              rv_ff, rv_in;
   rsp_type           rd_ff, rd_in;

   logic signed [15:0] sky_q, lo_q, up_q;
   logic [SkyAw-1:0]   sky_ra, sky_wa;
   logic               sky_we;
   logic signed [15:0] sky_wd;
   logic [SkyAw:0]     width;
   logic signed [16:0] d, v;
   logic signed [17:0] term;
   logic [25:0]        wsum;
   logic               load_wr;
   logic [ProAw-1:0]   load_wa;

   assign width = (bin_ff > 11'(SkylineCells)) ? (SkyAw+1)'(SkylineCells)
                                               : (SkyAw+1)'(bin_ff);
   assign d    = 17'(sky_q) - 17'(lo_q);
   assign v    = 17'(up_q) + plift_ff;
   assign term = 18'(lo_q) + 18'(lift_ff) - 18'(sky_q);
   assign wsum = 26'(waste_ff) + 26'(unsigned'(term));

   // a new profile starts at column 0; drop columns past the store
   assign load_wr = state_ff == ST_IDLE && req.valid && req.ready
                    && req.data.kind == KIND_LOAD
                    && (closed_ff || len_ff < (ProAw+1)'(ProfileCells));
   assign load_wa = closed_ff ? '0 : len_ff[ProAw-1:0];

   always_ff @(posedge clock) begin
      if (sky_we) sky_mem[sky_wa] <= sky_wd;
      sky_q <= sky_mem[sky_ra];
      lo_q  <= lo_mem[i_ff[ProAw-1:0]];
      up_q  <= up_mem[i_ff[ProAw-1:0]];
      if (load_wr) begin
         lo_mem[load_wa] <= req.data.lower_edge;
         up_mem[load_wa] <= req.data.upper_edge;
      end
   end

   always_comb begin
      sky_ra = SkyAw'(x_ff + SkyAw'(i_ff));
      if (state_ff == ST_WR_RD || state_ff == ST_WR)
         sky_ra = SkyAw'(px_ff + SkyAw'(i_ff));
      sky_we = 1'b0;
      sky_wa = SkyAw'(px_ff + SkyAw'(i_ff));
      sky_wd = (v > 17'sd32767) ? 16'sd32767 : 16'(v);
      if (state_ff == ST_CLEAR) begin
         sky_we = 1'b1;
         sky_wa = clr_ff[SkyAw-1:0];
         sky_wd = '0;
      end else if (state_ff == ST_WR) begin
         sky_we = 1'b1;
      end
   end

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = rv_ff;
   assign rsp.data  = rd_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               if (req.data.kind == KIND_CLEAR) state_in = ST_CLEAR;
               else if (req.data.kind == KIND_PLACE) state_in = ST_NEXT;
            end
         end
         ST_CLEAR:    if (clr_ff == (SkyAw+1)'(SkylineCells - 1)) state_in = ST_IDLE;
         ST_NEXT: begin
            if ((SkyAw+2)'(x_ff) + (SkyAw+2)'(len_ff) > (SkyAw+2)'(width))
               state_in = found_ff ? ST_WR_RD : ST_DONE;
            else
               state_in = ST_LIFT_RD;
         end
         ST_LIFT_RD:  state_in = (i_ff == len_ff) ? ST_LIFT : ST_LIFT_RD;
         ST_LIFT:     state_in = ST_WASTE_RD;
         ST_WASTE_RD: state_in = (i_ff == len_ff) ? ST_WASTE : ST_WASTE_RD;
         ST_WASTE:    state_in = ST_NEXT;
         ST_WR_RD:    state_in = (i_ff == len_ff) ? ST_DONE : ST_WR;
         ST_WR:       state_in = ST_WR_RD;
         ST_DONE:     state_in = (rv_ff && !rsp.ready) ? ST_DONE : ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      len_in = len_ff; closed_in = closed_ff; x_in = x_ff; i_in = i_ff;
      clr_in = clr_ff; lift_in = lift_ff; waste_in = waste_ff;
      height_in = height_ff; found_in = found_ff; px_in = px_ff;
      plift_in = plift_ff; pwaste_in = pwaste_ff; rd_in = rd_ff;
      rv_in = rv_ff && !rsp.ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               if (req.data.kind == KIND_CLEAR) clr_in = '0;
               if (req.data.kind == KIND_LOAD) begin
                  len_in = closed_ff ? '0 : len_ff;
                  if (len_in < (ProAw+1)'(ProfileCells)) len_in = len_in + 1'b1;
                  closed_in = req.data.last_column;
               end
               if (req.data.kind == KIND_PLACE) begin
                  height_in = req.data.chart_height;
                  x_in = '0; found_in = 1'b0;
                  px_in = '0; plift_in = '0; pwaste_in = '0;
               end
            end
         end
         ST_CLEAR: clr_in = clr_ff + 1'b1;
         ST_NEXT: begin
            i_in = '0; lift_in = '0; waste_in = '0;
         end
         ST_LIFT_RD: begin
            // data of column i-1 arrives in the cycle after its read
            if (i_ff != 0 && d > lift_ff) lift_in = d;
            i_in = i_ff + 1'b1;
            if (i_ff == len_ff) i_in = i_ff;
         end
         ST_LIFT: begin
            i_in = '0;
         end
         ST_WASTE_RD: begin
            if (i_ff != 0) waste_in = (wsum > 26'(WasteMax)) ? WasteMax : wsum[23:0];
            i_in = i_ff + 1'b1;
            if (i_ff == len_ff) i_in = i_ff;
         end
         ST_WASTE: begin
            if (17'(unsigned'(lift_ff)) + 17'(height_ff) < 17'(bin_ff)) begin
               if (!found_ff || waste_in < pwaste_ff) begin
                  found_in = 1'b1; px_in = x_ff; plift_in = lift_ff;
                  pwaste_in = waste_in;
               end
            end
            x_in = x_ff + 1'b1;
         end
         ST_WR_RD: begin
            i_in = i_ff;
            if (i_ff == '0 && state_ff != ST_WR) i_in = i_ff;
         end
         ST_WR: i_in = i_ff + 1'b1;
         ST_DONE: begin
            // hold until the output register is free
            if (!rv_ff || rsp.ready) begin
               rv_in = 1'b1;
               rd_in.placed     = found_ff;
               rd_in.pos_x      = 10'(px_ff);
               rd_in.pos_y      = 10'(plift_ff);
               rd_in.waste_area = pwaste_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR; clr_ff <= '0; bin_ff <= 11'd1024;
         len_ff <= '0; closed_ff <= 1'b1; rv_ff <= 1'b0;
         found_ff <= 1'b0; x_ff <= '0; i_ff <= '0;
      end else begin
         state_ff <= state_in; clr_ff <= clr_in;
         if (csr_wr_en) bin_ff <= csr_wr_data;
         len_ff <= len_in; closed_ff <= closed_in; rv_ff <= rv_in;
         found_ff <= found_in; x_ff <= x_in;
         i_ff <= (state_ff == ST_NEXT || state_ff == ST_DONE) ? '0 :
                 (state_ff == ST_WASTE && state_in == ST_WR_RD) ? '0 : i_in;
      end
      lift_ff <= lift_in; waste_ff <= waste_in; height_ff <= height_in;
      px_ff <= px_in; plift_ff <= plift_in; pwaste_ff <= pwaste_in;
      rd_ff <= rd_in;
   end

endmodule

/* design/scp_checker.sv */
// ----------------------------------------------------------------------------
// Chart placer port checker
// Port level checks, bound to the top level.
// ----------------------------------------------------------------------------
module scp_checker import scp_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped while stalled");

   a_unplaced_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.placed |-> rsp_data.pos_x == '0
         && rsp_data.pos_y == '0 && rsp_data.waste_area == '0)
      else $error("unplaced result not zero");

   a_place_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.kind == KIND_PLACE |=> !req_ready)
      else $error("accepted item during placement");

   a_no_rsp_load: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.kind == KIND_LOAD && !rsp_valid
      |=> !rsp_valid)
      else $error("result from load item");

endmodule

bind skyline_chart_placer scp_checker u_scp_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready), .req_data(req.data),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);
